### sv/mpec_pkg.sv
// Shared types, constants and calibration tables of the median resistance block.
package mpec_pkg;

   localparam int WINDOW_DEF  = 7;
   localparam int LEVEL_W     = 10;
   localparam int RES_W       = 26;
   localparam int SEG_N       = 15;
   localparam int SEG_W       = 4;
   localparam int SLOPE_W     = 13;
   localparam int NUM_W       = 26;
   localparam int SCALE_W     = 17;
   localparam int PROD_W      = NUM_W + SCALE_W;
   localparam int FRAC_W      = 16;
   localparam int Q1_W        = PROD_W - FRAC_W;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SCALE_W-1:0] SCALE   = SCALE_W'(100000);
   localparam logic [RES_W-1:0]   RES_MAX = {RES_W{1'b1}};

   localparam logic [LEVEL_W-1:0] SEG_UPPER [SEG_N-1] = '{
      10'd11, 10'd23, 10'd47, 10'd94, 10'd162, 10'd186, 10'd259,
      10'd310, 10'd358, 10'd401, 10'd432, 10'd458, 10'd479, 10'd525
   };

   localparam logic [NUM_W-1:0] SEG_OFFSET [SEG_N] = '{
      26'd0, 26'd28836, 26'd112525, 26'd513363, 26'd2238710, 26'd2403009,
      26'd6100805, 26'd10289152, 26'd13575317, 26'd17825792, 26'd21491129,
      26'd24497979, 26'd27090944, 26'd31056783, 26'd34457374
   };

   localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_N] = '{
      13'd5000, 13'd4800, 13'd4530, 13'd3920, 13'd2720, 13'd2670, 13'd1610,
      13'd1020, 13'd690, 13'd390, 13'd220, 13'd120, 13'd70, 13'd10, 13'd1
   };

   typedef enum logic [2:0] {
      CAL_IDLE,
      CAL_MUL,
      CAL_START,
      CAL_WAIT,
      CAL_DONE
   } cal_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic                start;
      logic [Q1_W-1:0]     dividend;
      logic [SLOPE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic [RES_W-1:0]    resistance;
      logic [LEVEL_W-1:0]  median_level;
      logic                saturated;
   } rsp_word_type;

   // pick the first segment whose upper bound is not below the level
   function automatic logic [SEG_W-1:0] seg_select(input logic [LEVEL_W-1:0] level);
      logic [SEG_W-1:0] seg;
      seg = SEG_W'(SEG_N - 1);
      for (int i = SEG_N - 2; i >= 0; i--) begin
         if (level <= SEG_UPPER[i]) begin
            seg = SEG_W'(i);
         end
      end
      return seg;
   endfunction

endpackage

### sv/median_piecewise_ec_resistance.sv
// Top level: median of a sample window, converted by piecewise-linear calibration.
//
//   channel | ports                                             | dir | handshake
//   --------+---------------------------------------------------+-----+---------------------
//   request | req_sample[9:0]                                   | in  | push / full
//   result  | rsp_resistance[25:0] rsp_median_level rsp_saturated| out | empty / pop
//
// Samples enter at one per cycle while full is low; every WINDOW-th sample closes
// the window and queues its median. Each median then passes through the calibration
// path, which includes a one-bit-per-cycle 27-step restoring divider. Synchronous reset
// empties the window, the median queue and the result register; no clearing pass.
// full rises only when the median queue is full; a held result stalls the next
// calibration in its last step but never blocks sample intake directly.
module median_piecewise_ec_resistance #(
   parameter int WINDOW = mpec_pkg::WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [mpec_pkg::LEVEL_W-1:0]  req_sample,
   output logic                          empty,
   input  logic                          pop,
   output logic [mpec_pkg::RES_W-1:0]    rsp_resistance,
   output logic [mpec_pkg::LEVEL_W-1:0]  rsp_median_level,
   output logic                          rsp_saturated
);
   import mpec_pkg::*;

   queue_status_type    q_status;
   logic                accept;
   logic                q_push, q_pop;
   logic [LEVEL_W-1:0]  q_median, q_head;
   logic                rsp_valid, rsp_take;
   rsp_word_type        rsp_word;

   // take a word only when the median queue has room
   assign full     = q_status.full;
   assign accept   = push && !full;
   assign empty    = !rsp_valid;
   assign rsp_take = pop && rsp_valid;

   mpec_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .sample   (req_sample),
      .q_push   (q_push),
      .q_median (q_median)
   );

   mpec_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_level (q_median),
      .pop        (q_pop),
      .head_level (q_head),
      .status     (q_status)
   );

   mpec_calib u_calib (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_level   (q_head),
      .q_pop     (q_pop),
      .rsp_take  (rsp_take),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // drive the result ports from the held word
   assign rsp_resistance   = rsp_word.resistance;
   assign rsp_median_level = rsp_word.median_level;
   assign rsp_saturated    = rsp_word.saturated;

endmodule

### sv/mpec_front.sv
// Front end: sorted insertion of samples into the window and median pick.
module mpec_front #(
   parameter int WINDOW = mpec_pkg::WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [mpec_pkg::LEVEL_W-1:0]  sample,
   output logic                          q_push,
   output logic [mpec_pkg::LEVEL_W-1:0]  q_median
);
   import mpec_pkg::*;

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int MED   = (WINDOW - 1) / 2;

   logic [LEVEL_W-1:0] sort_ff [WINDOW];
   logic [LEVEL_W-1:0] sort_in [WINDOW];
   logic [WINDOW-1:0]  keep;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               last;

   // an entry stays put when it is held and not above the new sample
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         keep[i] = (CNT_W'(i) < cnt_ff) && (sort_ff[i] <= sample);
      end
   end

   // insert the sample, shift larger entries up by one
   always_comb begin
      sort_in[0] = keep[0] ? sort_ff[0] : sample;
      for (int i = 1; i < WINDOW; i++) begin
         if (keep[i]) begin
            sort_in[i] = sort_ff[i];
         end else if (keep[i-1]) begin
            sort_in[i] = sample;
         end else begin
            sort_in[i] = sort_ff[i-1];
         end
      end
   end

   assign last     = (cnt_ff == CNT_W'(WINDOW - 1));
   assign q_push   = accept && last;
   assign q_median = sort_in[MED];

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = last ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sort_ff <= sort_in;
      end
   end

endmodule

### sv/mpec_fifo.sv
// Short queue of window medians between the front end and the calibration.
module mpec_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [mpec_pkg::LEVEL_W-1:0]      push_level,
   input  logic                              pop,
   output logic [mpec_pkg::LEVEL_W-1:0]      head_level,
   output mpec_pkg::queue_status_type        status
);
   import mpec_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [LEVEL_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_level   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_level;
      end
   end

endmodule

### sv/mpec_div.sv
// Restoring divider, one quotient bit per cycle.
module mpec_div (
   input  logic                          clock,
   input  logic                          reset,
   input  mpec_pkg::div_req_type         req,
   output logic                          done,
   output logic [mpec_pkg::Q1_W-1:0]     quotient
);
   import mpec_pkg::*;

   localparam int STEP_W = $clog2(Q1_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SLOPE_W-1:0]  rem_ff, rem_in;
   logic [SLOPE_W-1:0]  den_ff, den_in;
   logic [Q1_W-1:0]     quo_ff, quo_in;
   logic [SLOPE_W:0]    partial, diff;
   logic                fits;

   assign partial = {rem_ff, quo_ff[Q1_W-1]};
   assign fits    = partial >= {1'b0, den_ff};
   assign diff    = partial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(Q1_W - 1);
         rem_in  = '0;
         den_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         // subtract when the divisor fits, shift in the quotient bit
         rem_in = fits ? diff[SLOPE_W-1:0] : partial[SLOPE_W-1:0];
         quo_in = {quo_ff[Q1_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/mpec_calib.sv
// Back end: segment lookup, scaling, division and result register.
module mpec_calib (
   input  logic                          clock,
   input  logic                          reset,
   input  mpec_pkg::queue_status_type    q_status,
   input  logic [mpec_pkg::LEVEL_W-1:0]  q_level,
   output logic                          q_pop,
   input  logic                          rsp_take,
   output logic                          rsp_valid,
   output mpec_pkg::rsp_word_type        rsp_word
);
   import mpec_pkg::*;

   cal_state_type       state_ff, state_in;
   logic                load_en, mul_en, wr_en;
   logic                div_start;
   div_req_type         div_req;
   logic                div_done;
   logic [Q1_W-1:0]     div_quo;

   logic [LEVEL_W-1:0]  level_ff;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [SLOPE_W-1:0]  slope_ff;
   logic [Q1_W-1:0]     q1_ff;
   logic [PROD_W-1:0]   prod;
   logic [SEG_W-1:0]    seg;
   logic [NUM_W-1:0]    lvl_q16;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CAL_IDLE:  if (!q_status.empty) state_in = CAL_MUL;
         CAL_MUL:   state_in = CAL_START;
         CAL_START: state_in = CAL_WAIT;
         CAL_WAIT:  if (div_done) state_in = CAL_DONE;
         CAL_DONE:  if (!rsp_valid_ff || rsp_take) state_in = CAL_IDLE;
         default:   state_in = CAL_IDLE;
      endcase
   end

   // strobes
   always_comb begin
      load_en   = 1'b0;
      mul_en    = 1'b0;
      div_start = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         CAL_IDLE:  load_en   = !q_status.empty;
         CAL_MUL:   mul_en    = 1'b1;
         CAL_START: div_start = 1'b1;
         CAL_WAIT:  ;
         CAL_DONE:  wr_en     = !rsp_valid_ff || rsp_take;
         default:   ;
      endcase
   end

   assign q_pop   = load_en;
   assign div_req = '{start: div_start, dividend: q1_ff, divisor: slope_ff};

   // difference to the segment offset, floored at zero
   assign seg     = seg_select(q_level);
   assign lvl_q16 = {q_level, {FRAC_W{1'b0}}};
   assign num_in  = (lvl_q16 > SEG_OFFSET[seg]) ? lvl_q16 - SEG_OFFSET[seg] : '0;
   assign prod    = PROD_W'(num_ff) * PROD_W'(SCALE);

   always_comb begin
      rsp_word_in.median_level = level_ff;
      if (div_quo > Q1_W'(RES_MAX)) begin
         rsp_word_in.resistance = RES_MAX;
         rsp_word_in.saturated  = 1'b1;
      end else begin
         rsp_word_in.resistance = div_quo[RES_W-1:0];
         rsp_word_in.saturated  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CAL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         level_ff <= q_level;
         num_ff   <= num_in;
         slope_ff <= SEG_SLOPE[seg];
      end
      if (mul_en) begin
         q1_ff <= prod[PROD_W-1:FRAC_W];
      end
      if (wr_en) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   mpec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### sv/mpec_checker.sv
// Port-level checks of the median resistance block, bound to the top level.
module mpec_checker #(
   parameter int WINDOW = mpec_pkg::WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic                          empty,
   input  logic                          pop,
   input  logic [mpec_pkg::RES_W-1:0]    rsp_resistance,
   input  logic [mpec_pkg::LEVEL_W-1:0]  rsp_median_level,
   input  logic                          rsp_saturated
);
   import mpec_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int PEND_W = 4;

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              closes, taken;

   // count words into the window and windows not yet popped
   assign closes = push && !full && (fill_ff == CNT_W'(WINDOW - 1));
   assign taken  = pop && !empty;

   always_comb begin
      fill_in = fill_ff;
      if (push && !full) begin
         fill_in = closes ? '0 : fill_ff + CNT_W'(1);
      end
      pend_in = pend_ff + PEND_W'(closes) - PEND_W'(taken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result present right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_resistance)
                            && $stable(rsp_median_level) && $stable(rsp_saturated)))
      else $error("stalled result changed or vanished");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_saturated) |-> (rsp_resistance == RES_MAX))
      else $error("saturated flag without clamped resistance");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (pend_ff != '0))
      else $error("result shown without a completed window");

endmodule

bind median_piecewise_ec_resistance mpec_checker #(
   .WINDOW (WINDOW)
) u_mpec_checker (
   .clock            (clock),
   .reset            (reset),
   .push             (push),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_resistance   (rsp_resistance),
   .rsp_median_level (rsp_median_level),
   .rsp_saturated    (rsp_saturated)
);

### sim/tb_top.sv
// Self-checking bench for the median-filtered probe resistance block.
`timescale 1ns / 1ps

module tb_top;
   import mpec_pkg::*;

   localparam int WIN        = WINDOW_DEF;
   localparam int MID_IDX    = (WIN - 1) / 2;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_WAIT  = 100;
   localparam int RAND_WINS  = 185;

   localparam longint unsigned RES_LIMIT = (64'd1 << RES_W) - 1;

   // calibration breakpoints, Q16 offsets and slopes in units of 1e-5
   localparam int unsigned SEG_TOP [14] = '{
      11, 23, 47, 94, 162, 186, 259, 310, 358, 401, 432, 458, 479, 525
   };
   localparam longint unsigned SEG_OFS [15] = '{
      0, 28836, 112525, 513363, 2238710, 2403009, 6100805, 10289152,
      13575317, 17825792, 21491129, 24497979, 27090944, 31056783, 34457374
   };
   localparam longint unsigned SEG_SLP [15] = '{
      5000, 4800, 4530, 3920, 2720, 2670, 1610, 1020, 690, 390, 220, 120,
      70, 10, 1
   };

   // Scoreboard: rebuilds each window, predicts its reading, checks arrivals.
   class reading_scoreboard;
      logic [LEVEL_W-1:0] open_window [$];
      rsp_word_type       expected_readings [$];
      int                 failures;

      function new();
         failures = 0;
      endfunction

      function logic [LEVEL_W-1:0] middle_level();
         logic [LEVEL_W-1:0] arr [WIN];
         logic [LEVEL_W-1:0] v;
         int                 j;
         for (int i = 0; i < WIN; i++) arr[i] = open_window[i];
         for (int i = 1; i < WIN; i++) begin
            v = arr[i];
            j = i - 1;
            while (j >= 0 && arr[j] > v) begin
               arr[j + 1] = arr[j];
               j--;
            end
            arr[j + 1] = v;
         end
         return arr[MID_IDX];
      endfunction

      function rsp_word_type level_to_ohms(logic [LEVEL_W-1:0] level);
         rsp_word_type    w;
         int              seg;
         longint unsigned lq, num, q;
         seg = 0;
         while (seg < 14 && level > SEG_TOP[seg]) seg++;
         lq  = longint'(level) << 16;
         num = (lq > SEG_OFS[seg]) ? lq - SEG_OFS[seg] : 64'd0;
         q   = (num * 64'd100000) / (SEG_SLP[seg] << 16);
         w.saturated    = (q > RES_LIMIT);
         w.resistance   = w.saturated ? RES_W'(RES_LIMIT) : RES_W'(q);
         w.median_level = level;
         return w;
      endfunction

      function void note_sample(logic [LEVEL_W-1:0] s);
         open_window.push_back(s);
         if (open_window.size() == WIN) begin
            expected_readings.push_back(level_to_ohms(middle_level()));
            open_window.delete();
         end
      endfunction

      function void report(string what, longint exp_v, longint got_v);
         failures++;
         if (failures <= 10)
            $display("%0t: %s mismatch: expected %0d got %0d", $realtime, what, exp_v, got_v);
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp_w;
         if (expected_readings.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected reading res=%0d level=%0d sat=%0b", $realtime,
                        got.resistance, got.median_level, got.saturated);
            return;
         end
         exp_w = expected_readings.pop_front();
         if (got.resistance !== exp_w.resistance)
            report("resistance", exp_w.resistance, got.resistance);
         if (got.median_level !== exp_w.median_level)
            report("median_level", exp_w.median_level, got.median_level);
         if (got.saturated !== exp_w.saturated)
            report("saturated", exp_w.saturated, got.saturated);
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               pop = 1'b0;
   logic [LEVEL_W-1:0] req_sample = '0;
   logic               full, empty;
   logic [RES_W-1:0]   rsp_resistance;
   logic [LEVEL_W-1:0] rsp_median_level;
   logic               rsp_saturated;

   reading_scoreboard sb = new();
   bit                send_burst = 1'b0;
   bit                take_burst = 1'b0;
   int                idle_cycles = 0;

   median_piecewise_ec_resistance #(.WINDOW(WIN)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_sample       (req_sample),
      .empty            (empty),
      .pop              (pop),
      .rsp_resistance   (rsp_resistance),
      .rsp_median_level (rsp_median_level),
      .rsp_saturated    (rsp_saturated)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, none at all during a burst.
   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one word and hold it until the block takes it; leave push high.
   task automatic send_sample(input logic [LEVEL_W-1:0] s);
      int gap;
      gap = pick_gap(send_burst);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push       <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (full);
      sb.note_sample(s);
   endtask

   // Hold off the sender until every queued reading has been drained.
   task automatic drain_readings();
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Build one window whose median lands exactly on a chosen level.
   task automatic send_pinned_window(input int target);
      logic [LEVEL_W-1:0] vals [WIN];
      logic [LEVEL_W-1:0] t;
      int                 k;
      for (int i = 0; i < WIN; i++) begin
         if (i < MID_IDX)       vals[i] = LEVEL_W'($urandom_range(0, target));
         else if (i == MID_IDX) vals[i] = LEVEL_W'(target);
         else                   vals[i] = LEVEL_W'($urandom_range(target, 1023));
      end
      for (int i = WIN - 1; i > 0; i--) begin
         k       = $urandom_range(0, i);
         t       = vals[i];
         vals[i] = vals[k];
         vals[k] = t;
      end
      for (int i = 0; i < WIN; i++) send_sample(vals[i]);
   endtask

   // Stimulus: directed windows, then random windows of three flavors.
   initial begin
      int kind, target, center, spread, lo, hi;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero and all-full-scale windows hit both ends of the table
      repeat (WIN) send_sample(10'd0);
      repeat (WIN) send_sample(10'd1023);
      // duplicates around the last breakpoint, descending start
      send_sample(10'd1023);
      send_sample(10'd900);
      send_sample(10'd526);
      send_sample(10'd525);
      send_sample(10'd11);
      send_sample(10'd0);
      send_sample(10'd525);
      drain_readings();

      for (int w = 0; w < RAND_WINS; w++) begin
         send_burst = ($urandom_range(0, 99) < 20);
         kind       = $urandom_range(0, 99);
         if (kind < 45) begin
            repeat (WIN) send_sample(LEVEL_W'($urandom_range(0, 1023)));
         end else if (kind < 85) begin
            // median on or next to a segment edge, or a scale end
            target = $urandom_range(0, 15);
            if (target == 14)      target = 0;
            else if (target == 15) target = 1023;
            else                   target = SEG_TOP[target];
            target = target + $urandom_range(0, 2) - 1;
            if (target < 0)    target = 0;
            if (target > 1023) target = 1023;
            send_pinned_window(target);
         end else begin
            // tight cluster, sometimes a flat window
            center = $urandom_range(0, 1023);
            spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            lo     = (center - spread < 0) ? 0 : center - spread;
            hi     = (center + spread > 1023) ? 1023 : center + spread;
            repeat (WIN) send_sample(LEVEL_W'($urandom_range(lo, hi)));
         end
         if (w == RAND_WINS / 2) drain_readings();
      end

      // trailing partial window must produce nothing
      send_burst = 1'b0;
      repeat ($urandom_range(1, WIN - 1)) send_sample(LEVEL_W'($urandom_range(0, 1023)));
      push <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Reading side: random stalls, check each word as it is popped.
   initial begin
      int           stall;
      rsp_word_type got;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
         stall = pick_gap(take_burst);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got.resistance   = rsp_resistance;
         got.median_level = rsp_median_level;
         got.saturated    = rsp_saturated;
         sb.check_result(got);
      end
   end

   // Watchdog: end the run if neither side moves a word for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
